### sv/shabsh_pkg.sv
// Shared types and constants for the SHA-256 byte stream hasher.
// Holds the round constants, the initial hash words and the core control struct.
// Depends on nothing; the core, the top level and the testbench import it.
package shabsh_pkg;

    localparam int unsigned WordW    = 32;
    localparam int unsigned CountW   = 61;
    localparam int unsigned ChainN   = 8;
    localparam int unsigned BlockN   = 16;
    localparam int unsigned RoundN   = 64;

    localparam logic [7:0]        PadByte   = 8'h80;
    localparam logic [5:0]        LenPos    = 6'd56;
    localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};

    localparam logic [31:0] RoundK [RoundN] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] InitH [ChainN] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Control from the sequencer to the round core.
    typedef struct packed {
        logic       load_msg;    // shift a message word into the schedule window
        logic       load_state;  // shift a chaining word into the working state
        logic       round_en;    // run one compression round
        logic       final_shift; // step the working state during the final add
        logic [5:0] round_idx;
    } core_ctrl_t;

endpackage

### sv/shabsh_if.sv
// Handshake channel interfaces for the SHA-256 byte stream hasher.
// One interface for the input byte stream and one for the digest words.
// Depends on nothing.
interface shabsh_stream_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

interface shabsh_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    logic        failed;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, output failed, input ready);
    modport sink (input valid, input digest_word, input word_index,
                  input last_word, input failed, output ready);
endinterface

### sv/shabsh_core.sv
// Round core: 16-word message schedule window and the eight working variables.
// One SHA-256 round per enabled cycle; loaded word by word from the memories.
// Depends on shabsh_pkg.
module shabsh_core (
    input  logic                    clk,
    input  shabsh_pkg::core_ctrl_t  ctrl,
    input  logic [31:0]             msg_word,
    input  logic [31:0]             chain_word,
    output logic [31:0]             state_head
);
    import shabsh_pkg::*;

    logic [31:0] w_reg  [BlockN];
    logic [31:0] st_reg [ChainN];
    logic [31:0] w_new;
    logic [31:0] t1;
    logic [31:0] t2;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

    // Schedule expansion and round function.
    always_comb
    begin
        w_new = w_reg[0]
              + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
              + w_reg[9]
              + (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10));
        t1 = st_reg[7]
           + (rotr(st_reg[4], 6) ^ rotr(st_reg[4], 11) ^ rotr(st_reg[4], 25))
           + ((st_reg[4] & st_reg[5]) ^ (~st_reg[4] & st_reg[6]))
           + RoundK[ctrl.round_idx] + w_reg[0];
        t2 = (rotr(st_reg[0], 2) ^ rotr(st_reg[0], 13) ^ rotr(st_reg[0], 22))
           + ((st_reg[0] & st_reg[1]) ^ (st_reg[0] & st_reg[2]) ^ (st_reg[1] & st_reg[2]));
    end

    // Schedule window: loads shift in at the top, rounds slide it forward.
    always_ff @(posedge clk)
    begin
        if (ctrl.load_msg || ctrl.round_en)
        begin
            for (int i = 0; i < BlockN - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[BlockN-1] <= ctrl.load_msg ? msg_word : w_new;
        end
    end

    // Working variables a..h.
    always_ff @(posedge clk)
    begin
        if (ctrl.round_en)
        begin
            st_reg[0] <= t1 + t2;
            st_reg[1] <= st_reg[0];
            st_reg[2] <= st_reg[1];
            st_reg[3] <= st_reg[2];
            st_reg[4] <= st_reg[3] + t1;
            st_reg[5] <= st_reg[4];
            st_reg[6] <= st_reg[5];
            st_reg[7] <= st_reg[6];
        end
        else if (ctrl.load_state || ctrl.final_shift)
        begin
            for (int i = 0; i < ChainN - 1; i++)
            begin
                st_reg[i] <= st_reg[i+1];
            end
            st_reg[ChainN-1] <= chain_word;
        end
    end

    assign state_head = st_reg[0];

endmodule

### sv/sha256_byte_stream_hasher_unit.sv
// Top level of the SHA-256 byte stream hasher: sequencer, block and chain memories.
// Instantiates shabsh_core; uses shabsh_pkg and the channel interfaces in shabsh_if.
//
//   channel | dir | payload                                         | accepted when
//   stream  | in  | data_byte[7:0], has_byte, last                  | valid && ready
//   digest  | out | digest_word[31:0], word_index[2:0], last_word, failed | valid && ready
//
// Bytes are taken one per cycle while the block fills. A full block stalls the stream
// while the message and chaining memories load, the rounds run and the result is added
// back into the chaining memory. Padding then emits one byte per cycle, pausing while
// a full block is compressed. Each digest word is read, registered and held until taken.
// Reset restores the initial hash words through a fresh flag on the chain memory.
module sha256_byte_stream_hasher_unit (
    input  logic            clk,
    input  logic            rst_n,
    shabsh_stream_if.sink   stream,
    shabsh_digest_if.source digest
);
    import shabsh_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_LOAD, S_ROUND, S_FINAL, S_OUT_RD, S_OUT_LD, S_OUT_HOLD
    } state_t;

    state_t              state_reg, state_next;
    state_t              ret_reg, ret_next;
    logic [5:0]          fill_reg, fill_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [CountW-1:0]   count_reg, count_next;
    logic                failed_reg, failed_next;
    logic                fresh_reg, fresh_next;
    logic                pad_first_reg, pad_first_next;
    logic                len_ok_reg, len_ok_next;
    logic [2:0]          idx_reg, idx_next;
    logic [23:0]         word_reg, word_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         out_word_reg, out_word_next;

    // Memories and their registered read ports.
    logic [31:0] msg_mem   [BlockN];
    logic [31:0] chain_mem [ChainN];
    logic [31:0] msg_rd_reg;
    logic [31:0] chain_rd_reg;

    logic        put_en;
    logic [7:0]  put_val;
    logic        msg_we;
    logic        chain_we;
    logic [2:0]  chain_waddr;
    logic [2:0]  chain_raddr;
    logic        msg_re;
    logic        chain_re;
    logic [63:0] len_shift;
    logic        accept;
    logic [31:0] state_head;
    core_ctrl_t  ctrl;

    assign accept    = stream.valid && stream.ready;
    assign len_shift = {count_reg, 3'b000} << {fill_reg[2:0], 3'b000};

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        count_next     = count_reg;
        failed_next    = failed_reg;
        fresh_next     = fresh_reg;
        pad_first_next = pad_first_reg;
        len_ok_next    = len_ok_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        put_en         = 1'b0;
        put_val        = stream.data_byte;
        msg_re         = 1'b0;
        chain_re       = 1'b0;
        chain_raddr    = cnt_reg[2:0];
        chain_we       = 1'b0;
        chain_waddr    = 3'(cnt_reg - 6'd1);
        ctrl           = '0;
        ctrl.round_idx = cnt_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stream.has_byte && !failed_reg)
                    begin
                        if (count_reg == CountMax)
                        begin
                            failed_next = 1'b1;
                        end
                        else
                        begin
                            count_next = count_reg + 1'b1;
                            put_en     = 1'b1;
                        end
                    end
                    pad_first_next = 1'b1;
                    len_ok_next    = 1'b0;
                    if (stream.last)
                    begin
                        if (failed_next)
                        begin
                            idx_next   = '0;
                            state_next = S_OUT_RD;
                        end
                        else if (put_en && fill_reg == 6'd63)
                        begin
                            ret_next   = S_PAD;
                            cnt_next   = '0;
                            state_next = S_LOAD;
                        end
                        else
                        begin
                            state_next = S_PAD;
                        end
                    end
                    else if (put_en && fill_reg == 6'd63)
                    begin
                        ret_next   = S_IDLE;
                        cnt_next   = '0;
                        state_next = S_LOAD;
                    end
                end
            end

            S_PAD:
            begin
                put_en         = 1'b1;
                pad_first_next = 1'b0;
                if (pad_first_reg)
                begin
                    put_val     = PadByte;
                    len_ok_next = fill_reg < LenPos;
                end
                else if (len_ok_reg && fill_reg >= LenPos)
                begin
                    put_val = len_shift[63:56];
                end
                else
                begin
                    put_val = 8'h00;
                end
                if (fill_reg == 6'd63)
                begin
                    cnt_next   = '0;
                    state_next = S_LOAD;
                    if (len_ok_reg && !pad_first_reg)
                    begin
                        ret_next = S_OUT_RD;
                        idx_next = '0;
                    end
                    else
                    begin
                        ret_next    = S_PAD;
                        len_ok_next = 1'b1;
                    end
                end
            end

            S_LOAD:
            begin
                msg_re   = cnt_reg < 6'd16;
                chain_re = cnt_reg < 6'd8;
                ctrl.load_msg   = cnt_reg != 6'd0;
                ctrl.load_state = (cnt_reg != 6'd0) && (cnt_reg <= 6'd8);
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == 6'd16)
                begin
                    cnt_next   = '0;
                    state_next = S_ROUND;
                end
            end

            S_ROUND:
            begin
                ctrl.round_en = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (ctrl.round_idx == 6'd63)
                begin
                    cnt_next   = '0;
                    state_next = S_FINAL;
                end
            end

            S_FINAL:
            begin
                chain_re         = cnt_reg < 6'd8;
                chain_we         = cnt_reg != 6'd0;
                ctrl.final_shift = cnt_reg != 6'd0;
                cnt_next         = cnt_reg + 1'b1;
                if (cnt_reg == 6'd8)
                begin
                    fresh_next = 1'b0;
                    cnt_next   = '0;
                    state_next = ret_reg;
                end
            end

            S_OUT_RD:
            begin
                chain_re    = 1'b1;
                chain_raddr = idx_reg;
                state_next  = S_OUT_LD;
            end

            S_OUT_LD:
            begin
                out_valid_next = 1'b1;
                out_word_next  = failed_reg ? 32'h0 : chain_rd_reg;
                state_next     = S_OUT_HOLD;
            end

            S_OUT_HOLD:
            begin
                if (digest.ready)
                begin
                    out_valid_next = 1'b0;
                    if (idx_reg == 3'd7)
                    begin
                        fill_next   = '0;
                        count_next  = '0;
                        failed_next = 1'b0;
                        fresh_next  = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_OUT_RD;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (put_en)
        begin
            fill_next = fill_reg + 1'b1;
        end
    end

    assign msg_we    = put_en && (fill_reg[1:0] == 2'b11);
    assign word_next = put_en ? {word_reg[15:0], put_val} : word_reg;

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            count_reg     <= '0;
            failed_reg    <= 1'b0;
            fresh_reg     <= 1'b1;
            pad_first_reg <= 1'b0;
            len_ok_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            failed_reg    <= failed_next;
            fresh_reg     <= fresh_next;
            pad_first_reg <= pad_first_next;
            len_ok_reg    <= len_ok_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        word_reg     <= word_next;
        out_word_reg <= out_word_next;
    end

    // Message block memory: one word written per four bytes, read during load.
    always_ff @(posedge clk)
    begin
        if (msg_we)
        begin
            msg_mem[fill_reg[5:2]] <= {word_reg, put_val};
        end
        if (msg_re)
        begin
            msg_rd_reg <= msg_mem[cnt_reg[3:0]];
        end
    end

    // Chaining memory: read-add-write back; reads give the initial words while fresh.
    always_ff @(posedge clk)
    begin
        if (chain_we)
        begin
            chain_mem[chain_waddr] <= chain_rd_reg + state_head;
        end
        if (chain_re)
        begin
            chain_rd_reg <= fresh_reg ? InitH[chain_raddr] : chain_mem[chain_raddr];
        end
    end

    shabsh_core u_core (
        .clk        (clk),
        .ctrl       (ctrl),
        .msg_word   (msg_rd_reg),
        .chain_word (chain_rd_reg),
        .state_head (state_head)
    );

    assign stream.ready       = state_reg == S_IDLE;
    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = idx_reg;
    assign digest.last_word   = idx_reg == 3'd7;
    assign digest.failed      = failed_reg;

endmodule

### dv/tb_sha256_byte_stream_hasher_unit.sv
// Testbench for the SHA-256 byte stream hasher: drives byte requests, predicts digests.
// Depends on shabsh_pkg, the channel interfaces in shabsh_if and the unit top level.
// A scoreboard class computes SHA-256 per message and checks each digest word in order.
`timescale 1ns / 1ps

module tb_sha256_byte_stream_hasher_unit;
    import shabsh_pkg::*;

    // One expected digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
        logic        failed;
    } digest_rec_t;

    // Predicts digest words from accepted byte requests and checks the outputs.
    class digest_scoreboard;
        logic [31:0]   chain [ChainN];
        logic [31:0]   blk [BlockN];
        int unsigned   fill;
        logic [63:0]   nbytes;
        digest_rec_t   pending [$];
        int unsigned   mismatches;
        int unsigned   words_seen;
        int unsigned   messages;

        function new();
            mismatches = 0;
            words_seen = 0;
            messages = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < ChainN; i++) chain[i] = InitH[i];
            fill = 0;
            nbytes = '0;
        endfunction

        function logic [31:0] rotr(logic [31:0] v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        // One 64-round compression of the current block into the chain.
        function void compress_block();
            logic [31:0] w [RoundN];
            logic [31:0] a, b, c, d, e, f, g, h, t1, t2;
            for (int i = 0; i < 16; i++) w[i] = blk[i];
            for (int i = 16; i < RoundN; i++)
                w[i] = w[i-16] + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                     + w[i-7] + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
            a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
            e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
            for (int i = 0; i < RoundN; i++) begin
                t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                   + RoundK[i] + w[i];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                h = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
            chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
        endfunction

        function void put_byte(logic [7:0] v);
            int unsigned sh;
            sh = (3 - (fill % 4)) * 8;
            blk[fill / 4] = (blk[fill / 4] & ~(32'hff << sh)) | (32'(v) << sh);
            fill++;
            if (fill == 64)
            begin
                compress_block();
                fill = 0;
            end
        endfunction

        // Notes one accepted request. The length cannot reach the overflow limit
        // in simulation, so the failed flag is always expected low.
        function void note_request(logic [7:0] data_byte, logic has_byte, logic last);
            logic [63:0] bits;
            digest_rec_t r;
            if (has_byte)
            begin
                nbytes++;
                put_byte(data_byte);
            end
            if (!last) return;
            bits = nbytes * 8;
            put_byte(PadByte);
            while (fill != LenPos) put_byte(8'h00);
            for (int i = 0; i < 8; i++) put_byte(bits[(7-i)*8 +: 8]);
            for (int i = 0; i < ChainN; i++)
            begin
                r.digest_word = chain[i];
                r.word_index = 3'(i);
                r.last_word = (i == 7);
                r.failed = 1'b0;
                pending.push_back(r);
            end
            messages++;
            restart();
        endfunction

        function void check_word(digest_rec_t got);
            digest_rec_t want;
            words_seen++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected digest word %h index %0d", got.digest_word,
                             got.word_index);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: digest exp word=%h idx=%0d last=%b fail=%b, got word=%h idx=%0d last=%b fail=%b",
                             want.digest_word, want.word_index, want.last_word, want.failed,
                             got.digest_word, got.word_index, got.last_word, got.failed);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    shabsh_stream_if stream ();
    shabsh_digest_if digest ();

    digest_scoreboard sb;
    int unsigned idle_cycles;
    int unsigned requests_sent;
    bit hold_off;
    bit timed_out;

    sha256_byte_stream_hasher_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream.sink),
        .digest (digest.source)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned gap_len();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offers one request and waits for it to be taken.
    task automatic send_request(logic [7:0] b, logic hb, logic lst);
        stream.valid <= 1'b1;
        stream.data_byte <= b;
        stream.has_byte <= hb;
        stream.last <= lst;
        do @(posedge clk); while (!stream.ready);
        sb.note_request(b, hb, lst);
        requests_sent++;
    endtask

    task automatic idle_stream(int unsigned n);
        if (n == 0) return;
        stream.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // A message of the given length with random bytes, and random gaps when asked.
    task automatic send_message(int unsigned len, bit gaps, bit empty_tail);
        for (int unsigned i = 0; i < len; i++)
        begin
            send_request(8'($urandom), 1'b1, (i == len - 1) && !empty_tail);
            if (gaps) idle_stream(gap_len());
        end
        if (len == 0 || empty_tail) send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        stream.valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    // Digest side: random stalls, or a long hold-off when asked.
    initial
    begin
        digest.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                digest.ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            digest.ready <= (gap_len() == 0) || ($urandom_range(3) == 0);
        end
    end

    // Checks digest words and counts cycles with no progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (digest.valid && digest.ready)
                sb.check_word({digest.digest_word, digest.word_index, digest.last_word,
                               digest.failed});
            if ((digest.valid && digest.ready) || (stream.valid && stream.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int unsigned len;
        sb = new();
        idle_cycles = 0;
        requests_sent = 0;
        hold_off = 1'b0;
        rst_n = 1'b0;
        stream.valid = 1'b0;
        stream.data_byte = '0;
        stream.has_byte = 1'b0;
        stream.last = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, byte extremes, items with no effect.
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'hff, 1'b0, 1'b0);
        send_request(8'h00, 1'b1, 1'b0);
        send_request(8'hff, 1'b1, 1'b0);
        send_request(8'h55, 1'b0, 1'b0);
        send_request(8'haa, 1'b1, 1'b1);
        send_request(8'hff, 1'b1, 1'b1);
        send_message(3, 1'b0, 1'b1);
        wait_drained();

        // Padding boundaries: 55, 56 and 64 bytes.
        send_message(55, 1'b0, 1'b0);
        send_message(56, 1'b1, 1'b0);
        send_message(64, 1'b0, 1'b1);

        // Fill the digest path while the receiver holds off.
        hold_off = 1'b1;
        for (int k = 0; k < 6; k++)
            send_message($urandom_range(4), 1'b0, 1'($urandom_range(1)));
        wait_drained();

        // Random messages, mostly short, some crossing block boundaries.
        while (requests_sent < 410)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(130, 50) : $urandom_range(12);
            send_message(len, 1'($urandom_range(1)), $urandom_range(3) == 0);
            if ($urandom_range(9) == 0) idle_stream(gap_len());
        end
        stream.valid <= 1'b0;

        while (sb.pending.size() != 0 && !timed_out) @(posedge clk);
        repeat (200) @(posedge clk);
        if (timed_out) disable watchdog_wait;
        $display("Covered %0d requests in %0d messages, %0d digest words checked.",
                 requests_sent, sb.messages, sb.words_seen);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("sha256_byte_stream_hasher_unit verification clean");
        else
            $display("sha256_byte_stream_hasher_unit verification failed");
        $finish;
    end

    // Watchdog: stops the run when nothing moves for too long.
    initial
    begin : watchdog_wait
        timed_out = 1'b0;
        wait (idle_cycles >= 5000);
        timed_out = 1'b1;
        $display("ERROR: timeout with %0d digest words outstanding", sb.pending.size());
        $display("sha256_byte_stream_hasher_unit verification failed");
        $finish;
    end
endmodule

### sha256_byte_stream_hasher_unit.f
sv/shabsh_pkg.sv
sv/shabsh_if.sv
sv/shabsh_core.sv
sv/sha256_byte_stream_hasher_unit.sv
dv/tb_sha256_byte_stream_hasher_unit.sv
